>>> rtl/lfu_pkg.sv
// Shared constants, command/status structs and state type for the LFU page replacement block.
`default_nettype none
package lfu_pkg;

   localparam int PAGE_IN_BITS    = 16;
   localparam int FRAME_OUT_BITS  = 4;
   localparam int EVICT_OUT_BITS  = 16;
   localparam int FAULT_BITS      = 32;
   localparam int FRAMES_CFG_BITS = 5;
   localparam logic [FRAMES_CFG_BITS-1:0] FRAMES_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/lfu_interfaces.sv
// Valid/ready channel interfaces: page reference, result and configuration write.
`default_nettype none
interface lfu_req_if;
   logic                             valid;
   logic                             ready;
   logic [lfu_pkg::PAGE_IN_BITS-1:0] page_number;
   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lfu_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic [lfu_pkg::FRAME_OUT_BITS-1:0] frame_used;
   logic                               evicted_valid;
   logic [lfu_pkg::EVICT_OUT_BITS-1:0] evicted_page;
   logic [lfu_pkg::FAULT_BITS-1:0]     fault_total;
   modport source (output valid, output hit, output frame_used, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input frame_used, input evicted_valid,
                   input evicted_page, input fault_total, output ready);
endinterface

interface lfu_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lfu_pkg::FRAMES_CFG_BITS-1:0] frames_in_use;
   modport source (output valid, output frames_in_use, input ready);
   modport sink   (input valid, input frames_in_use, output ready);
endinterface
`default_nettype wire

>>> rtl/lfu_datapath.sv
// Frame store, scan trackers, fault counter, config register and result register.
`default_nettype none
module lfu_datapath #(
   parameter int FRAME_COUNT = 16,
   parameter int PAGE_BITS   = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lfu_pkg::cmd_type                 cmd,
   output lfu_pkg::status_type              status,
   input  logic [lfu_pkg::PAGE_IN_BITS-1:0] page_number,
   lfu_rsp_if.source                        rsp,
   lfu_csr_if.sink                          csr
);
   import lfu_pkg::*;

   localparam int IDX_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int N_BITS   = $clog2(FRAME_COUNT + 1);

   typedef struct packed {
      logic [PAGE_BITS-1:0]  page;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   entry_type                  mem [FRAME_COUNT];
   logic [FRAME_COUNT-1:0]     valid_ff;
   logic [FRAMES_CFG_BITS-1:0] frames_ff;
   logic [PAGE_BITS-1:0]       page_ff;
   logic [IDX_BITS-1:0]        addr_ff;

   logic                       rd_valid_ff;
   logic [IDX_BITS-1:0]        rd_idx_ff;
   entry_type                  rd_entry_ff;
   logic                       rd_vld_ff;

   logic                       found_ff;
   logic [IDX_BITS-1:0]        match_idx_ff;
   logic [COUNT_BITS-1:0]      match_count_ff;
   logic [IDX_BITS-1:0]        min_idx_ff;
   logic [COUNT_BITS-1:0]      min_count_ff;
   logic                       min_vld_ff;
   logic [PAGE_BITS-1:0]       min_page_ff;

   logic [FAULT_BITS-1:0]      fault_ff;
   logic [FAULT_BITS-1:0]      fault_in;

   logic                       rsp_valid_ff;
   logic                       hit_ff;
   logic [FRAME_OUT_BITS-1:0]  frame_ff;
   logic                       ev_valid_ff;
   logic [EVICT_OUT_BITS-1:0]  ev_page_ff;
   logic [FAULT_BITS-1:0]      total_ff;

   logic [N_BITS-1:0]          n_active;
   logic [31:0]                page_wide;
   logic [COUNT_BITS-1:0]      rd_count;
   logic                       rd_match;
   logic [IDX_BITS-1:0]        wr_idx;
   logic [COUNT_BITS-1:0]      wr_count;
   logic [31:0]                slot_wide;
   logic [31:0]                evict_wide;

   // active frame count, clamped to 1..FRAME_COUNT
   always_comb begin
      if (frames_ff == '0) begin
         n_active = N_BITS'(1);
      end else if (32'(frames_ff) > 32'(FRAME_COUNT)) begin
         n_active = N_BITS'(FRAME_COUNT);
      end else begin
         n_active = N_BITS'(frames_ff);
      end
   end

   assign status.scan_last = ((N_BITS'(addr_ff) + N_BITS'(1)) == n_active);
   assign status.out_free  = !rsp_valid_ff || rsp.ready;
   assign csr.ready        = 1'b1;

   assign page_wide = 32'(page_number);
   assign rd_count  = rd_vld_ff ? rd_entry_ff.count : '0;
   assign rd_match  = rd_vld_ff && (rd_entry_ff.page == page_ff);

   always_comb begin
      if (found_ff) begin
         wr_idx   = match_idx_ff;
         wr_count = (match_count_ff == '1) ? match_count_ff : match_count_ff + 1'b1;
         fault_in = fault_ff;
      end else begin
         wr_idx   = min_idx_ff;
         wr_count = COUNT_BITS'(1);
         fault_in = (fault_ff == '1) ? fault_ff : fault_ff + 1'b1;
      end
      slot_wide  = 32'(wr_idx);
      evict_wide = (!found_ff && min_vld_ff) ? 32'(min_page_ff) : 32'd0;
   end

   // frame store: one read port for the scan, one write at commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         mem[wr_idx] <= '{page: page_ff, count: wr_count};
      end
      if (cmd.read) begin
         rd_entry_ff <= mem[addr_ff];
         rd_vld_ff   <= valid_ff[addr_ff];
         rd_idx_ff   <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         frames_ff    <= FRAMES_RESET;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         addr_ff      <= '0;
         found_ff     <= 1'b0;
      end else begin
         if (csr.valid) begin
            frames_ff <= csr.frames_in_use;
         end
         rd_valid_ff <= cmd.read;
         if (cmd.start) begin
            addr_ff  <= '0;
            found_ff <= 1'b0;
         end else if (cmd.read && !status.scan_last) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (rd_valid_ff && !found_ff && rd_match) begin
            found_ff <= 1'b1;
         end
         if (cmd.commit) begin
            valid_ff[wr_idx] <= 1'b1;
            fault_ff         <= fault_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan trackers and result payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff <= page_wide[PAGE_BITS-1:0];
      end
      if (rd_valid_ff) begin
         if (!found_ff && rd_match) begin
            match_idx_ff   <= rd_idx_ff;
            match_count_ff <= rd_entry_ff.count;
         end
         if ((rd_idx_ff == '0) || (rd_count < min_count_ff)) begin
            min_idx_ff   <= rd_idx_ff;
            min_count_ff <= rd_count;
            min_vld_ff   <= rd_vld_ff;
            min_page_ff  <= rd_entry_ff.page;
         end
      end
      if (cmd.commit) begin
         hit_ff      <= found_ff;
         frame_ff    <= slot_wide[FRAME_OUT_BITS-1:0];
         ev_valid_ff <= !found_ff && min_vld_ff;
         ev_page_ff  <= evict_wide[EVICT_OUT_BITS-1:0];
         total_ff    <= fault_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit           = hit_ff;
   assign rsp.frame_used    = frame_ff;
   assign rsp.evicted_valid = ev_valid_ff;
   assign rsp.evicted_page  = ev_page_ff;
   assign rsp.fault_total   = total_ff;

endmodule
`default_nettype wire

>>> rtl/lfu_ctrl.sv
// Sequencing state machine: accept, frame scan, drain, commit.
`default_nettype none
module lfu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lfu_pkg::status_type status,
   output lfu_pkg::cmd_type    cmd
);
   import lfu_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/lfu_page_replacement.sv
// LFU page replacement top level: controller plus frame datapath.
// A transaction is accepted only in idle, and no new one until the last is committed: the scan
// reads one frame per cycle through the frame store's single read port over the n active frames,
// then a drain state, then commit, which waits until the result register is free and loads it.
// Reset: all frames empty at once, fault count 0, frames_in_use 16; no clearing pass.
`default_nettype none
module lfu_page_replacement #(
   parameter int FRAME_COUNT = 16,
   parameter int PAGE_BITS   = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   lfu_req_if.sink   req,
   lfu_rsp_if.source rsp,
   lfu_csr_if.sink   csr
);
   import lfu_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req.ready = req_ready;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_datapath #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_BITS   (PAGE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .page_number (req.page_number),
      .rsp         (rsp),
      .csr         (csr)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("transaction accepted while another is in progress");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp.valid)
      else $error("commit did not load the result register");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.hit) |-> !rsp.evicted_valid)
      else $error("hit reported an eviction");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
      else $error("evicted page non-zero without eviction");

   a_fault_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.hit) |-> (rsp.fault_total != '0))
      else $error("fault reported with zero fault total");

endmodule
`default_nettype wire

>>> verif/lfu_page_replacement_tb.sv
// Self-checking testbench for lfu_page_replacement: directed table and random traffic.
`default_nettype none
module lfu_page_replacement_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lfu_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int FRAME_SLOTS  = 16;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PHASE_ITEMS  = 90;

   typedef struct packed {
      logic                      hit;
      logic [FRAME_OUT_BITS-1:0] frame;
      logic                      ev_valid;
      logic [EVICT_OUT_BITS-1:0] ev_page;
      logic [FAULT_BITS-1:0]     faults;
   } lfu_result_type;

   typedef struct {
      lfu_result_type predicted;
      bit             pinned;
      lfu_result_type want;
   } pending_entry_type;

   typedef enum logic {ROW_REF, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [15:0]       value;
      bit                pinned;
      lfu_result_type    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   lfu_req_if req_ch ();
   lfu_rsp_if rsp_ch ();
   lfu_csr_if csr_ch ();

   lfu_page_replacement u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // frame table mirror
   logic [PAGE_IN_BITS-1:0]    fr_page  [FRAME_SLOTS];
   bit                         fr_valid [FRAME_SLOTS];
   logic [15:0]                fr_count [FRAME_SLOTS];
   logic [FAULT_BITS-1:0]      fault_tally;
   logic [FRAMES_CFG_BITS-1:0] frames_cfg;

   pending_entry_type pending_results[$];
   stim_row_type      directed_rows[$];
   logic [15:0]       page_pool[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  burst_left = 0;
   bit  paced = 1'b1;
   bit  long_hold_req = 1'b0;
   int  hold_left = 0;
   int  phase_left = 0;
   bit  stalling = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic lfu_result_type predict_reference(input logic [PAGE_IN_BITS-1:0] page);
      int             n;
      int             slot;
      bit             found;
      logic [15:0]    best;
      logic [15:0]    c;
      lfu_result_type r;
      n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAME_SLOTS) ? FRAME_SLOTS : int'(frames_cfg));
      slot = 0;
      found = 1'b0;
      best = '0;
      r = '0;
      for (int i = 0; i < n; i++) begin
         if (!found && fr_valid[i] && fr_page[i] == page) begin
            slot = i;
            found = 1'b1;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         if (fr_count[slot] != 16'hFFFF) fr_count[slot]++;
      end else begin
         for (int i = 0; i < n; i++) begin
            c = fr_valid[i] ? fr_count[i] : 16'd0;
            if (i == 0 || c < best) begin
               best = c;
               slot = i;
            end
         end
         if (fr_valid[slot]) begin
            r.ev_valid = 1'b1;
            r.ev_page  = fr_page[slot];
         end
         fr_page[slot]  = page;
         fr_valid[slot] = 1'b1;
         fr_count[slot] = 16'd1;
         if (fault_tally != '1) fault_tally++;
      end
      r.frame  = slot[FRAME_OUT_BITS-1:0];
      r.faults = fault_tally;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns mismatch %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result(input lfu_result_type got, input lfu_result_type want,
                               input string tag);
      if (got.hit !== want.hit)
         report_mismatch({tag, " hit"}, 32'(got.hit), 32'(want.hit));
      if (got.frame !== want.frame)
         report_mismatch({tag, " frame_used"}, 32'(got.frame), 32'(want.frame));
      if (got.ev_valid !== want.ev_valid)
         report_mismatch({tag, " evicted_valid"}, 32'(got.ev_valid), 32'(want.ev_valid));
      if (got.ev_page !== want.ev_page)
         report_mismatch({tag, " evicted_page"}, 32'(got.ev_page), 32'(want.ev_page));
      if (got.faults !== want.faults)
         report_mismatch({tag, " fault_total"}, got.faults, want.faults);
   endtask

   function automatic void add_row(input row_kind_type kind, input logic [15:0] value,
                                   input bit pinned = 1'b0, input lfu_result_type want = '0);
      stim_row_type row;
      row.kind   = kind;
      row.value  = value;
      row.pinned = pinned;
      row.want   = want;
      directed_rows.push_back(row);
   endfunction

   task automatic send_reference(input logic [PAGE_IN_BITS-1:0] page, input bit pinned = 1'b0,
                                 input lfu_result_type want = '0);
      pending_entry_type entry;
      if (paced && burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_ch.valid       <= 1'b1;
      req_ch.page_number <= page;
      do @(posedge clock); while (!req_ch.ready);
      entry.predicted = predict_reference(page);
      entry.pinned    = pinned;
      entry.want      = want;
      pending_results.push_back(entry);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic write_frames(input logic [FRAMES_CFG_BITS-1:0] value);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.frames_in_use <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      frames_cfg = value;
   endtask

   // result checker
   always @(posedge clock) begin
      lfu_result_type    got;
      pending_entry_type entry;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.hit, rsp_ch.frame_used, rsp_ch.evicted_valid, rsp_ch.evicted_page,
                rsp_ch.fault_total};
         if (pending_results.size() == 0) begin
            report_mismatch("transaction with nothing pending", got.faults, 32'd0);
         end else begin
            entry = pending_results.pop_front();
            check_result(got, entry.predicted, "predicted");
            if (entry.pinned) check_result(got, entry.want, "table");
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!paced) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stalling = ~stalling;
            phase_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 25);
            if (!stalling && $urandom_range(0, 7) == 0) phase_left = 150;
         end
         phase_left--;
         rsp_ch.ready <= !stalling;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lfu_page_replacement verification failed");
         $finish;
      end
   end

   initial begin
      logic [FRAMES_CFG_BITS-1:0] phase_cfg [10];
      int                         n;
      int                         pick;
      logic [15:0]                page;

      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.page_number   = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.frames_in_use = '0;

      for (int i = 0; i < FRAME_SLOTS; i++) begin
         fr_page[i]  = '0;
         fr_valid[i] = 1'b0;
         fr_count[i] = '0;
      end
      fault_tally = '0;
      frames_cfg  = FRAMES_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(ROW_REF, 16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1});
      add_row(ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2});
      add_row(ROW_REF, 16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2});
      add_row(ROW_REF, 16'h0000);
      add_row(ROW_REF, 16'h8001);
      add_row(ROW_REF, 16'h7FFE);
      add_row(ROW_CFG, 16'd2);
      add_row(ROW_REF, 16'h8001);
      add_row(ROW_CFG, 16'd0);
      add_row(ROW_REF, 16'h8001);
      add_row(ROW_REF, 16'h8001);
      add_row(ROW_CFG, 16'd31);
      add_row(ROW_REF, 16'h7FFE);
      add_row(ROW_REF, 16'h8001);
      add_row(ROW_REF, 16'h1234);
      add_row(ROW_CFG, 16'd17);
      add_row(ROW_REF, 16'h5555);
      add_row(ROW_CFG, 16'd16);
      add_row(ROW_REF, 16'hAAAA);
      add_row(ROW_REF, 16'h0000);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG)
            write_frames(directed_rows[i].value[FRAMES_CFG_BITS-1:0]);
         else
            send_reference(directed_rows[i].value, directed_rows[i].pinned, directed_rows[i].want);
      end

      phase_cfg = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};
      phase_cfg[7] = FRAMES_CFG_BITS'($urandom_range(0, 31));
      for (int ph = 0; ph < 10; ph++) begin
         write_frames(phase_cfg[ph]);
         n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAME_SLOTS) ? FRAME_SLOTS : int'(frames_cfg));
         page_pool.delete();
         repeat (n + $urandom_range(0, n + 2))
            page_pool.push_back(16'($urandom_range(0, 16'hFFFF)));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 2 && k == 20) long_hold_req = 1'b1;
            if (ph == 6 && k == 45) begin
               req_ch.valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)      page = page_pool[$urandom_range(0, page_pool.size() - 1)];
            else if (pick < 90) page = 16'($urandom_range(0, 16'hFFFF));
            else if (pick < 95) page = 16'h0000;
            else                page = 16'hFFFF;
            send_reference(page);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("lfu_page_replacement verification clean");
      end else begin
         $display("lfu_page_replacement verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
